### sv/ctm_pkg.sv
// shared constants, codes and width helpers for the scalar to rgb colour map
// used by ctm_rem_pipe, ctm_div_pipe and scalar_to_rgb_colour_map, no dependencies
package ctm_pkg;

	localparam int SAMPLE_WIDTH    = 16;
	localparam int RANGE_WIDTH     = 16;
	localparam int CFG_WIDTH       = 16;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int MAP_WIDTH       = 3;
	localparam int SPAN_WIDTH      = RANGE_WIDTH + 1;
	localparam int LEVEL_WIDTH     = 8;
	localparam int DIVIDEND_WIDTH  = LEVEL_WIDTH + RANGE_WIDTH;
	localparam int REM_STEP        = 4;
	localparam int DIV_STEP        = 2;
	localparam int DIV_STAGES      = LEVEL_WIDTH / DIV_STEP;
	localparam int DIV_LATENCY     = DIV_STAGES + 1;
	localparam int SEG_WIDTH       = 3;

	// register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAP_SELECT = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_REVERSE    = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_LOW  = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_HIGH = 2'd3;

	localparam logic signed [RANGE_WIDTH-1:0] RANGE_LOW_RESET  = 16'sd0;
	localparam logic signed [RANGE_WIDTH-1:0] RANGE_HIGH_RESET = 16'sd32767;

	// map codes
	localparam logic [MAP_WIDTH-1:0] MAP_JET     = 3'd0;
	localparam logic [MAP_WIDTH-1:0] MAP_HOT     = 3'd1;
	localparam logic [MAP_WIDTH-1:0] MAP_COLD    = 3'd2;
	localparam logic [MAP_WIDTH-1:0] MAP_GREY    = 3'd3;
	localparam logic [MAP_WIDTH-1:0] MAP_CYCLIC  = 3'd4;
	localparam logic [MAP_WIDTH-1:0] MAP_GENERAL = 3'd5;
	localparam logic [MAP_WIDTH-1:0] MAP_BLUE    = 3'd6;

	// segment codes of the piecewise maps
	localparam logic [SEG_WIDTH-1:0] SEG_BLACK = 3'd0;
	localparam logic [SEG_WIDTH-1:0] SEG_0     = 3'd1;
	localparam logic [SEG_WIDTH-1:0] SEG_1     = 3'd2;
	localparam logic [SEG_WIDTH-1:0] SEG_2     = 3'd3;
	localparam logic [SEG_WIDTH-1:0] SEG_3     = 3'd4;
	localparam logic [SEG_WIDTH-1:0] SEG_TOP   = 3'd5;

	localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX    = 8'd255;
	localparam logic [LEVEL_WIDTH-1:0] JET_BASE     = 8'd144;
	localparam logic [LEVEL_WIDTH-1:0] GENERAL_BASE = 8'd192;
	localparam logic [LEVEL_WIDTH-1:0] JET_SLOPE    = 8'd111;
	localparam logic [LEVEL_WIDTH-1:0] GENERAL_SLOPE = 8'd63;

	function automatic int ext_width(int sw);
		return (sw > RANGE_WIDTH) ? sw : RANGE_WIDTH;
	endfunction

	function automatic int value_width(int sw);
		return ext_width(sw) + 2;
	endfunction

	function automatic int rem_stages(int w);
		return (w + REM_STEP - 1) / REM_STEP;
	endfunction

endpackage

### sv/ctm_delay.sv
// delay line that carries valid bits and side data alongside the arithmetic units
// depends on nothing but its parameters
module ctm_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] line_q [0:DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				line_q[k] <= '0;
			end
		end else if (adv) begin
			line_q[0] <= din;
			for (int k = 1; k < DEPTH; k++) begin
				line_q[k] <= line_q[k-1];
			end
		end
	end

	assign dout = line_q[DEPTH-1];

endmodule

### sv/ctm_rem_pipe.sv
// pipelined remainder of a signed value by the span, magnitude and sign kept apart
// uses ctm_pkg for widths and the bits handled per stage
module ctm_rem_pipe #(
	parameter int VALUE_WIDTH = ctm_pkg::value_width(ctm_pkg::SAMPLE_WIDTH)
) (
	input  logic                            clk,
	input  logic                            adv,
	input  logic signed [VALUE_WIDTH-1:0]   value,
	input  logic [ctm_pkg::SPAN_WIDTH-1:0]  divisor,
	output logic [ctm_pkg::SPAN_WIDTH-1:0]  rem,
	output logic                            neg
);

	localparam int STAGES    = ctm_pkg::rem_stages(VALUE_WIDTH);
	localparam int PAD_WIDTH = STAGES * ctm_pkg::REM_STEP;
	localparam int SW        = ctm_pkg::SPAN_WIDTH;

	logic [PAD_WIDTH-1:0] mag_q [0:STAGES];
	logic [SW-1:0]        rem_q [0:STAGES];
	logic                 neg_q [0:STAGES];
	logic [PAD_WIDTH-1:0] mag_d [0:STAGES-1];
	logic [SW-1:0]        rem_d [0:STAGES-1];
	logic [VALUE_WIDTH-1:0] mag_in;

	assign mag_in = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

	// restoring steps, msb first, remainder always below the span
	always_comb begin
		logic [PAD_WIDTH-1:0] m;
		logic [SW-1:0]        r;
		logic [SW:0]          x;
		for (int k = 0; k < STAGES; k++) begin
			m = mag_q[k];
			r = rem_q[k];
			for (int j = 0; j < ctm_pkg::REM_STEP; j++) begin
				x = {r, m[PAD_WIDTH-1]};
				m = m << 1;
				if (x >= {1'b0, divisor}) begin
					x = x - {1'b0, divisor};
				end
				r = x[SW-1:0];
			end
			mag_d[k] = m;
			rem_d[k] = r;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_q[0] <= PAD_WIDTH'(mag_in);
			rem_q[0] <= '0;
			neg_q[0] <= value[VALUE_WIDTH-1];
			for (int k = 0; k < STAGES; k++) begin
				mag_q[k+1] <= mag_d[k];
				rem_q[k+1] <= rem_d[k];
				neg_q[k+1] <= neg_q[k];
			end
		end
	end

	assign rem = rem_q[STAGES];
	assign neg = neg_q[STAGES];

endmodule

### sv/ctm_div_pipe.sv
// pipelined level divider: floor(dividend / span) for quotients of eight bits
// uses ctm_pkg for widths and the quotient bits per stage
module ctm_div_pipe (
	input  logic                               clk,
	input  logic                               adv,
	input  logic [ctm_pkg::DIVIDEND_WIDTH-1:0] dividend,
	input  logic [ctm_pkg::SPAN_WIDTH-1:0]     divisor,
	output logic [ctm_pkg::LEVEL_WIDTH-1:0]    quotient
);

	localparam int N  = ctm_pkg::DIV_STAGES;
	localparam int DW = ctm_pkg::DIVIDEND_WIDTH;
	localparam int LW = ctm_pkg::LEVEL_WIDTH;
	localparam int EW = DW + 1;

	logic [DW-1:0] d_q [0:N];
	logic [LW-1:0] q_q [0:N];
	logic [DW-1:0] d_d [0:N-1];
	logic [LW-1:0] q_d [0:N-1];

	// dividend is below 256 times the span, so eight restoring steps suffice
	always_comb begin
		logic [DW-1:0] d;
		logic [LW-1:0] q;
		logic [EW-1:0] ext;
		for (int k = 0; k < N; k++) begin
			d = d_q[k];
			q = q_q[k];
			for (int j = 0; j < ctm_pkg::DIV_STEP; j++) begin
				ext = EW'(divisor) << (LW - 1 - k * ctm_pkg::DIV_STEP - j);
				if ({1'b0, d} >= ext) begin
					d = d - ext[DW-1:0];
					q = {q[LW-2:0], 1'b1};
				end else begin
					q = {q[LW-2:0], 1'b0};
				end
			end
			d_d[k] = d;
			q_d[k] = q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_q[0] <= dividend;
			q_q[0] <= '0;
			for (int k = 0; k < N; k++) begin
				d_q[k+1] <= d_d[k];
				q_q[k+1] <= q_d[k];
			end
		end
	end

	assign quotient = q_q[N];

endmodule

### sv/scalar_to_rgb_colour_map.sv
// throughput: one item per cycle unless out_stall holds a full output register; the depth
// from accepted sample to pixel follows from the remainder pipeline (four bits per stage)
// and the level dividers (two quotient bits per stage)
// reset: map jet, no mirror, range 0..32767, pipeline empty
// uses ctm_pkg, ctm_delay, ctm_rem_pipe and ctm_div_pipe
module scalar_to_rgb_colour_map #(
	parameter int SAMPLE_WIDTH = ctm_pkg::SAMPLE_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [ctm_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [ctm_pkg::CFG_WIDTH-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]       sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ctm_pkg::LEVEL_WIDTH-1:0]      red,
	output logic [ctm_pkg::LEVEL_WIDTH-1:0]      green,
	output logic [ctm_pkg::LEVEL_WIDTH-1:0]      blue,
	output logic                                 range_error
);

	localparam int XW      = ctm_pkg::ext_width(SAMPLE_WIDTH) + 1;
	localparam int VW      = ctm_pkg::value_width(SAMPLE_WIDTH);
	localparam int TW      = VW + 2;
	localparam int REM_LAT = ctm_pkg::rem_stages(VW) + 1;
	localparam int SPW     = ctm_pkg::SPAN_WIDTH;
	localparam int LW      = ctm_pkg::LEVEL_WIDTH;
	localparam int DW      = ctm_pkg::DIVIDEND_WIDTH;
	localparam int SGW     = ctm_pkg::SEG_WIDTH;

	typedef struct packed {
		logic neg;
		logic zero;
		logic lt1;
		logic gt2;
		logic lt3_1;
		logic lt3_2;
		logic lt4_1;
		logic lt4_2;
		logic lt4_3;
	} flags_t;

	logic [ctm_pkg::MAP_WIDTH-1:0]          map_select_q;
	logic                                   reverse_q;
	logic signed [ctm_pkg::RANGE_WIDTH-1:0] range_low_q;
	logic signed [ctm_pkg::RANGE_WIDTH-1:0] range_high_q;

	logic signed [SPW-1:0] span_full;
	logic [SPW-1:0]        span_u;
	logic                  span_err;
	logic signed [TW-1:0]  s1x;
	logic signed [TW-1:0]  s2x;
	logic signed [TW-1:0]  s3x;
	logic                  adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_select_q <= ctm_pkg::MAP_JET;
			reverse_q    <= 1'b0;
			range_low_q  <= ctm_pkg::RANGE_LOW_RESET;
			range_high_q <= ctm_pkg::RANGE_HIGH_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				ctm_pkg::REG_MAP_SELECT: map_select_q <= cfg_data[ctm_pkg::MAP_WIDTH-1:0];
				ctm_pkg::REG_REVERSE:    reverse_q    <= cfg_data[0];
				ctm_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_data;
				ctm_pkg::REG_RANGE_HIGH: range_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign span_full = SPW'(range_high_q) - SPW'(range_low_q);
	assign span_err  = span_full[SPW-1] || (span_full == '0);
	assign span_u    = span_full;
	assign s1x       = TW'(span_u);
	assign s2x       = s1x <<< 1;
	assign s3x       = s1x + s2x;

	// whole pipe moves together whenever the output register can take an item
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// s1: offset by range low
	logic                 valid_s1;
	logic signed [XW-1:0] v_s1;
	// s2: mirror within the span
	logic                 valid_s2;
	logic signed [VW-1:0] vm_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1  <= XW'(sample) - XW'(range_low_q);
			vm_s2 <= reverse_q ? (VW'(span_full) - VW'(v_s1)) : VW'(v_s1);
		end
	end

	// wrap for the cyclic map, value carried alongside
	logic [SPW-1:0]       rem_r;
	logic                 neg_r;
	logic                 valid_r;
	logic signed [VW-1:0] vm_r;

	ctm_rem_pipe #(.VALUE_WIDTH(VW)) u_rem (
		.clk     (clk),
		.adv     (adv),
		.value   (vm_s2),
		.divisor (span_u),
		.rem     (rem_r),
		.neg     (neg_r)
	);

	ctm_delay #(.WIDTH(VW + 1), .DEPTH(REM_LAT)) u_rem_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.din    ({valid_s2, vm_s2}),
		.dout   ({valid_r, vm_r})
	);

	logic [SPW-1:0] wrapped;
	assign wrapped = (neg_r && (rem_r != '0)) ? (span_u - rem_r) : rem_r;

	// s3: effective value, s4: segment tests, s5: segment and numerators
	logic                 valid_s3;
	logic signed [VW-1:0] veff_s3;
	logic                 valid_s4;
	flags_t               flags_s4;
	logic signed [TW-1:0] v_s4;
	logic signed [TW-1:0] t2_s4;
	logic signed [TW-1:0] t3_s4;
	logic signed [TW-1:0] t4_s4;
	logic                 valid_s5;
	logic [SGW-1:0]       seg_s5;
	logic [SPW-1:0]       num_a_s5;
	logic [SPW-1:0]       num_b_s5;
	logic [SPW-1:0]       num_c_s5;
	logic                 up_s5;
	logic                 k111_s5;

	logic signed [TW-1:0] vx;
	logic signed [TW-1:0] t2;
	logic signed [TW-1:0] t3;
	logic signed [TW-1:0] t4;
	flags_t               flags;

	assign vx = TW'(veff_s3);
	assign t2 = vx <<< 1;
	assign t4 = vx <<< 2;
	assign t3 = vx + t2;

	always_comb begin
		flags.neg   = veff_s3[VW-1];
		flags.zero  = (veff_s3 == '0);
		flags.lt1   = vx < s1x;
		flags.gt2   = t2 > s1x;
		flags.lt3_1 = t3 < s1x;
		flags.lt3_2 = t3 < s2x;
		flags.lt4_1 = t4 < s1x;
		flags.lt4_2 = t4 < s2x;
		flags.lt4_3 = t4 < s3x;
	end

	logic [SGW-1:0]       seg;
	logic signed [TW-1:0] pick_t;
	logic [1:0]           pick_k;
	logic                 up;
	logic                 k111;
	logic signed [TW-1:0] pick_ks;
	logic signed [TW-1:0] num_full;
	logic signed [TW-1:0] num_c_full;

	always_comb begin
		seg    = ctm_pkg::SEG_BLACK;
		pick_t = v_s4;
		pick_k = 2'd0;
		up     = 1'b0;
		k111   = 1'b0;
		case (map_select_q)
			ctm_pkg::MAP_JET: begin
				pick_t = t4_s4;
				if (flags_s4.neg) begin
					seg = ctm_pkg::SEG_BLACK;
				end else if (flags_s4.lt4_1) begin
					seg  = ctm_pkg::SEG_0;
					k111 = 1'b1;
				end else if (flags_s4.lt4_2) begin
					seg    = ctm_pkg::SEG_1;
					pick_k = 2'd1;
				end else if (flags_s4.lt4_3) begin
					seg    = ctm_pkg::SEG_2;
					pick_k = 2'd2;
				end else if (flags_s4.lt1) begin
					seg    = ctm_pkg::SEG_3;
					pick_k = 2'd3;
					up     = 1'b1;
				end else begin
					seg = ctm_pkg::SEG_TOP;
				end
			end
			ctm_pkg::MAP_HOT, ctm_pkg::MAP_COLD, ctm_pkg::MAP_CYCLIC: begin
				pick_t = t3_s4;
				if (flags_s4.neg) begin
					seg = ctm_pkg::SEG_BLACK;
				end else if (flags_s4.lt3_1) begin
					seg = ctm_pkg::SEG_0;
					up  = (map_select_q == ctm_pkg::MAP_CYCLIC);
				end else if (flags_s4.lt3_2) begin
					seg    = ctm_pkg::SEG_1;
					pick_k = 2'd1;
				end else if (flags_s4.lt1) begin
					seg    = ctm_pkg::SEG_2;
					pick_k = 2'd2;
				end else begin
					seg = ctm_pkg::SEG_TOP;
				end
			end
			ctm_pkg::MAP_GREY: begin
				if (flags_s4.neg || flags_s4.zero) begin
					seg = ctm_pkg::SEG_BLACK;
				end else if (!flags_s4.lt1) begin
					seg = ctm_pkg::SEG_TOP;
				end else begin
					seg = ctm_pkg::SEG_0;
				end
			end
			ctm_pkg::MAP_GENERAL: begin
				if (flags_s4.neg || flags_s4.zero) begin
					seg = ctm_pkg::SEG_BLACK;
				end else if (!flags_s4.lt1) begin
					seg = ctm_pkg::SEG_TOP;
				end else if (flags_s4.gt2) begin
					seg = ctm_pkg::SEG_1;
				end else begin
					seg = ctm_pkg::SEG_0;
				end
			end
			ctm_pkg::MAP_BLUE: begin
				if (flags_s4.neg) begin
					seg = ctm_pkg::SEG_BLACK;
				end else if (flags_s4.lt1) begin
					seg = ctm_pkg::SEG_0;
				end else begin
					seg = ctm_pkg::SEG_TOP;
				end
			end
			default: seg = ctm_pkg::SEG_BLACK;
		endcase
	end

	always_comb begin
		case (pick_k)
			2'd0:    pick_ks = '0;
			2'd1:    pick_ks = s1x;
			2'd2:    pick_ks = s2x;
			default: pick_ks = s3x;
		endcase
	end

	assign num_full   = pick_t - pick_ks;
	assign num_c_full = t2_s4 - s1x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_r;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			veff_s3  <= (map_select_q == ctm_pkg::MAP_CYCLIC) ? VW'(wrapped) : vm_r;
			flags_s4 <= flags;
			v_s4     <= vx;
			t2_s4    <= t2;
			t3_s4    <= t3;
			t4_s4    <= t4;
			seg_s5   <= seg;
			num_a_s5 <= num_full[SPW-1:0];
			num_b_s5 <= v_s4[SPW-1:0];
			num_c_s5 <= num_c_full[SPW-1:0];
			up_s5    <= up;
			k111_s5  <= k111;
		end
	end

	// dividends for the three level dividers
	logic [DW-1:0] div_a;
	logic [DW-1:0] div_b;
	logic [DW-1:0] div_c;
	logic [DW-1:0] round_a;

	assign round_a = up_s5 ? (DW'(span_u) - DW'(1'b1)) : '0;
	assign div_a   = (k111_s5 ? DW'(num_a_s5) * DW'(ctm_pkg::JET_SLOPE)
	                          : DW'(num_a_s5) * DW'(ctm_pkg::LEVEL_MAX)) + round_a;
	assign div_b   = DW'(num_b_s5) * DW'(ctm_pkg::GENERAL_SLOPE);
	assign div_c   = DW'(num_c_s5) * DW'(ctm_pkg::LEVEL_MAX);

	logic [LW-1:0]  qa;
	logic [LW-1:0]  qb;
	logic [LW-1:0]  qc;
	logic           valid_d;
	logic [SGW-1:0] seg_d;

	ctm_div_pipe u_div_a (
		.clk (clk), .adv (adv), .dividend (div_a), .divisor (span_u), .quotient (qa)
	);

	ctm_div_pipe u_div_b (
		.clk (clk), .adv (adv), .dividend (div_b), .divisor (span_u), .quotient (qb)
	);

	ctm_div_pipe u_div_c (
		.clk (clk), .adv (adv), .dividend (div_c), .divisor (span_u), .quotient (qc)
	);

	ctm_delay #(.WIDTH(SGW + 1), .DEPTH(ctm_pkg::DIV_LATENCY)) u_div_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.din    ({valid_s5, seg_s5}),
		.dout   ({valid_d, seg_d})
	);

	// pixel assembly
	logic [LW-1:0] r_c;
	logic [LW-1:0] g_c;
	logic [LW-1:0] b_c;
	logic [LW-1:0] hr;
	logic [LW-1:0] hg;
	logic [LW-1:0] hb;

	always_comb begin
		hr = '0;
		hg = '0;
		hb = '0;
		case (seg_d)
			ctm_pkg::SEG_0: hr = qa;
			ctm_pkg::SEG_1: begin
				hr = ctm_pkg::LEVEL_MAX;
				hg = qa;
			end
			ctm_pkg::SEG_2: begin
				hr = ctm_pkg::LEVEL_MAX;
				hg = ctm_pkg::LEVEL_MAX;
				hb = qa;
			end
			ctm_pkg::SEG_TOP: begin
				hr = ctm_pkg::LEVEL_MAX;
				hg = ctm_pkg::LEVEL_MAX;
				hb = ctm_pkg::LEVEL_MAX;
			end
			default: ;
		endcase
	end

	always_comb begin
		r_c = '0;
		g_c = '0;
		b_c = '0;
		case (map_select_q)
			ctm_pkg::MAP_JET: begin
				case (seg_d)
					ctm_pkg::SEG_0: b_c = ctm_pkg::JET_BASE + qa;
					ctm_pkg::SEG_1: begin
						g_c = qa;
						b_c = ctm_pkg::LEVEL_MAX;
					end
					ctm_pkg::SEG_2: begin
						r_c = qa;
						g_c = ctm_pkg::LEVEL_MAX;
						b_c = ~qa;
					end
					ctm_pkg::SEG_3: begin
						r_c = ctm_pkg::LEVEL_MAX;
						g_c = ~qa;
					end
					ctm_pkg::SEG_TOP: r_c = ctm_pkg::LEVEL_MAX;
					default: ;
				endcase
			end
			ctm_pkg::MAP_HOT: begin
				r_c = hr;
				g_c = hg;
				b_c = hb;
			end
			ctm_pkg::MAP_COLD: begin
				r_c = hb;
				g_c = hg;
				b_c = hr;
			end
			ctm_pkg::MAP_GREY: begin
				case (seg_d)
					ctm_pkg::SEG_0: begin
						r_c = qa;
						g_c = qa;
						b_c = qa;
					end
					ctm_pkg::SEG_TOP: begin
						r_c = ctm_pkg::LEVEL_MAX;
						g_c = ctm_pkg::LEVEL_MAX;
						b_c = ctm_pkg::LEVEL_MAX;
					end
					default: ;
				endcase
			end
			ctm_pkg::MAP_CYCLIC: begin
				case (seg_d)
					ctm_pkg::SEG_0: begin
						r_c = ~qa;
						b_c = qa;
					end
					ctm_pkg::SEG_1: begin
						g_c = qa;
						b_c = ~qa;
					end
					ctm_pkg::SEG_2: begin
						r_c = qa;
						g_c = ~qa;
					end
					default: ;
				endcase
			end
			ctm_pkg::MAP_GENERAL: begin
				case (seg_d)
					ctm_pkg::SEG_0: begin
						r_c = ctm_pkg::GENERAL_BASE + qb;
						g_c = qa;
					end
					ctm_pkg::SEG_1: begin
						r_c = ctm_pkg::GENERAL_BASE + qb;
						g_c = qa;
						b_c = qc;
					end
					ctm_pkg::SEG_TOP: begin
						r_c = ctm_pkg::LEVEL_MAX;
						g_c = ctm_pkg::LEVEL_MAX;
						b_c = ctm_pkg::LEVEL_MAX;
					end
					default: ;
				endcase
			end
			ctm_pkg::MAP_BLUE: begin
				case (seg_d)
					ctm_pkg::SEG_0:   b_c = qa;
					ctm_pkg::SEG_TOP: b_c = ctm_pkg::LEVEL_MAX;
					default: ;
				endcase
			end
			default: ;
		endcase
		// empty or reversed range gives black whatever the map
		if (span_err) begin
			r_c = '0;
			g_c = '0;
			b_c = '0;
		end
	end

	logic          valid_s7;
	logic [LW-1:0] red_s7;
	logic [LW-1:0] green_s7;
	logic [LW-1:0] blue_s7;
	logic          err_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s7 <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s7   <= r_c;
			green_s7 <= g_c;
			blue_s7  <= b_c;
			err_s7   <= span_err;
		end
	end

	assign out_valid   = valid_s7;
	assign red         = red_s7;
	assign green       = green_s7;
	assign blue        = blue_s7;
	assign range_error = err_s7;

endmodule
